// ----- rtl/adw_pkg.sv -----
// Shared types and constants for the Adam weight update block.
`timescale 1ns / 1ps
package adw_pkg;

    // Store depth; a power of two, element index is taken modulo this.
    localparam int WEIGHT_COUNT = 1024;
    localparam int ADDR_W       = $clog2(WEIGHT_COUNT);
    localparam int IDX_W        = 10;
    localparam int DATA_W       = 32;
    localparam int M_W          = 32;
    localparam int V_W          = 48;
    localparam int POW_W        = 33;

    // Multi-cycle multiplier: signed A times unsigned B, B in 16-bit chunks.
    localparam int MUL_A_W      = 66;
    localparam int MUL_B_W      = 64;
    localparam int CHUNK_W      = 16;
    localparam int MUL_CHUNKS   = MUL_B_W / CHUNK_W;
    localparam int ACC_W        = 130;

    // Divider and square root retire two bits per cycle.
    localparam int DIV_W        = 64;
    localparam int DIV_STEPS    = 2;
    localparam int DIV_CYC      = DIV_W / DIV_STEPS;
    localparam int SQRT_CYC     = (DIV_W / 2) / DIV_STEPS;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BETA_FIRST  = 2'd0;
    localparam logic [1:0] CFG_BETA_SECOND = 2'd1;
    localparam logic [1:0] CFG_STEP_SIZE   = 2'd2;
    localparam logic [1:0] CFG_DEN_FLOOR   = 2'd3;

    localparam logic [31:0] RST_BETA_FIRST  = 32'd3865470566;
    localparam logic [31:0] RST_BETA_SECOND = 32'd4290672329;
    localparam logic [31:0] RST_STEP_SIZE   = 32'd4294967;
    localparam logic [31:0] RST_DEN_FLOOR   = 32'd43;

    typedef struct packed {
        logic                       start;
        logic                       clr;
        logic signed [MUL_A_W-1:0]  a;
        logic [MUL_B_W-1:0]         b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   hi;
        logic [DIV_W-1:0]   lo;
        logic [DIV_W-1:0]   d;
    } t_div_req;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   x;
    } t_sqrt_req;

endpackage

// ----- rtl/adw_mul.sv -----
// Multi-cycle multiply-accumulate unit, one 16-bit chunk of B per cycle.
`timescale 1ns / 1ps
module adw_mul
    import adw_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mul_req                i_req,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_done
);

    localparam int CNT_W = $clog2(MUL_CHUNKS);

    logic signed [MUL_A_W-1:0]          r_a;
    logic [MUL_B_W-1:0]                 r_b;
    logic [CNT_W-1:0]                   r_cnt;
    logic                               r_busy;
    logic                               r_done;
    logic signed [ACC_W-1:0]            r_acc;
    logic [CHUNK_W-1:0]                 w_chunk;
    logic signed [MUL_A_W+CHUNK_W:0]    w_pp;
    logic signed [ACC_W-1:0]            w_pp_ext;

    always_comb begin
        w_chunk  = r_b[r_cnt*CHUNK_W +: CHUNK_W];
        w_pp     = r_a * $signed({1'b0, w_chunk});
        w_pp_ext = ACC_W'(w_pp) <<< (CHUNK_W * r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_CHUNKS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            if (i_req.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp_ext;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// ----- rtl/adw_div.sv -----
// Restoring divider for a 128-bit dividend, quotient saturated to 64 bits.
`timescale 1ns / 1ps
module adw_div
    import adw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic [DIV_W-1:0] o_quot,
    output logic             o_done
);

    localparam int CNT_W = $clog2(DIV_CYC);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_lo;
    logic [DIV_W-1:0] r_q;
    logic [DIV_W-1:0] r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W-1:0] n_lo;
    logic [DIV_W-1:0] n_q;

    always_comb begin
        logic [DIV_W:0] v_r;
        n_rem = r_rem;
        n_lo  = r_lo;
        n_q   = r_q;
        for (int s = 0; s < DIV_STEPS; s++) begin
            v_r  = {n_rem, n_lo[DIV_W-1]};
            n_lo = {n_lo[DIV_W-2:0], 1'b0};
            if (v_r >= {1'b0, r_d}) begin
                n_rem = DIV_W'(v_r - {1'b0, r_d});
                n_q   = {n_q[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = v_r[DIV_W-1:0];
                n_q   = {n_q[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= '0;
                if (i_req.hi >= i_req.d) begin
                    r_done <= 1'b1;      // quotient overflows: saturate
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.hi;
            r_lo  <= i_req.lo;
            r_d   <= i_req.d;
            r_q   <= (i_req.hi >= i_req.d) ? '1 : '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= n_lo;
            r_q   <= n_q;
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// ----- rtl/adw_sqrt.sv -----
// Integer square root of a 64-bit value, two result bits per cycle.
`timescale 1ns / 1ps
module adw_sqrt
    import adw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_sqrt_req            i_req,
    output logic [DIV_W/2-1:0]   o_root,
    output logic                 o_done
);

    localparam int CNT_W = $clog2(SQRT_CYC);

    logic [DIV_W-1:0] r_x;
    logic [DIV_W-1:0] r_res;
    logic [DIV_W-1:0] r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIV_W-1:0] n_x;
    logic [DIV_W-1:0] n_res;
    logic [DIV_W-1:0] n_bit;

    always_comb begin
        logic [DIV_W-1:0] v_t;
        n_x   = r_x;
        n_res = r_res;
        n_bit = r_bit;
        for (int s = 0; s < DIV_STEPS; s++) begin
            v_t = n_res + n_bit;
            if (n_x >= v_t) begin
                n_x   = n_x - v_t;
                n_res = (n_res >> 1) + n_bit;
            end else begin
                n_res = n_res >> 1;
            end
            n_bit = n_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.x;
            r_res <= '0;
            r_bit <= {2'b01, {(DIV_W-2){1'b0}}};
        end else if (r_busy) begin
            r_x   <= n_x;
            r_res <= n_res;
            r_bit <= n_bit;
        end
    end

    assign o_root = r_res[DIV_W/2-1:0];
    assign o_done = r_done;

endmodule

// ----- rtl/adam_weight_update.sv -----
// Adam weight update top level: moment memories, sequencer, arithmetic units.
// Flow: up to eight products on the 4-chunk multiplier (the two beta powers only when
//   index 0 starts a step), three divisions on the 2-bit-per-cycle divider (which does
//   not iterate when its quotient saturates) and the square root. The divisions, root
//   and final product are skipped when a bias-correction divisor is zero.
// One beat in flight; the next beat is taken once the result is in the output register.
// Reset: synchronous, active low. Control and config registers return to their defaults,
//   both beta powers to one, then a clearing pass zeroes every entry of the moment
//   memories while the input is stalled. Config writes are taken throughout.
`timescale 1ns / 1ps
module adam_weight_update
    import adw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config write port
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [IDX_W-1:0]         i_element_index,
    input  logic signed [DATA_W-1:0] i_weight_value,
    input  logic signed [DATA_W-1:0] i_gradient_value,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [IDX_W-1:0]         o_result_index,
    output logic signed [DATA_W-1:0] o_updated_weight
);

    // One-hot sequencer; each arithmetic state launches its unit, then waits.
    typedef enum logic [15:0] {
        S_CLEAR = 16'b0000_0000_0000_0001,
        S_IDLE  = 16'b0000_0000_0000_0010,
        S_POW1  = 16'b0000_0000_0000_0100,
        S_POW2  = 16'b0000_0000_0000_1000,
        S_M1    = 16'b0000_0000_0001_0000,
        S_M2    = 16'b0000_0000_0010_0000,
        S_GSQ   = 16'b0000_0000_0100_0000,
        S_V1    = 16'b0000_0000_1000_0000,
        S_V2    = 16'b0000_0001_0000_0000,
        S_WB    = 16'b0000_0010_0000_0000,
        S_DIV1  = 16'b0000_0100_0000_0000,
        S_DIV2  = 16'b0000_1000_0000_0000,
        S_SQRT  = 16'b0001_0000_0000_0000,
        S_QMUL  = 16'b0010_0000_0000_0000,
        S_QDIV  = 16'b0100_0000_0000_0000,
        S_DONE  = 16'b1000_0000_0000_0000
    } t_state;

    localparam logic [POW_W-1:0] ONE_Q32  = {1'b1, 32'd0};
    localparam logic [V_W-1:0]   MAX48    = '1;
    localparam int               DEN_W    = 41;
    localparam logic [33:0]      Q_LIMIT  = {1'b1, 33'd0};

    t_state r_state, n_state;
    logic   r_go;

    // config
    logic [DATA_W-1:0] r_beta1, r_beta2, r_step, r_floor;
    // running beta powers, Q1.32
    logic [POW_W-1:0]  r_p1, r_p2;

    // moment memories
    logic [M_W-1:0] r_mem_m [WEIGHT_COUNT];
    logic [V_W-1:0] r_mem_v [WEIGHT_COUNT];
    logic [M_W-1:0] r_m_rd;
    logic [V_W-1:0] r_v_rd;
    logic [ADDR_W:0] r_clr_cnt;

    // beat context and intermediates
    logic [IDX_W-1:0]         r_idx;
    logic [ADDR_W-1:0]        r_addr;
    logic signed [DATA_W-1:0] r_w, r_g;
    logic signed [M_W-1:0]    r_m;
    logic [V_W-1:0]           r_gsq, r_v;
    logic [DIV_W-1:0]         r_mhat, r_vhat, r_q;
    logic [DEN_W-1:0]         r_den;
    logic [2*DIV_W-1:0]       r_prod;

    // output register
    logic                     r_out_valid;
    logic [IDX_W-1:0]         r_out_idx;
    logic signed [DATA_W-1:0] r_out_w;

    // units
    t_mul_req                w_mul_req;
    t_div_req                w_div_req;
    t_sqrt_req               w_sqrt_req;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_mul_done;
    logic [DIV_W-1:0]        w_quot;
    logic                    w_div_done;
    logic [DIV_W/2-1:0]      w_root;
    logic                    w_sqrt_done;

    logic                    w_in_acc;
    logic                    w_out_free;
    logic [POW_W-1:0]        w_c1, w_c2;
    logic [DATA_W-1:0]       w_gabs;
    logic [M_W-1:0]          w_mabs;
    logic [DEN_W-1:0]        w_den;
    logic [33:0]             w_qc;
    logic signed [34:0]      w_nw;
    logic signed [DATA_W-1:0] w_nw_sat;
    logic                    w_wr;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_c1   = ONE_Q32 - r_p1;
    assign w_c2   = ONE_Q32 - r_p2;
    assign w_gabs = r_g[DATA_W-1] ? DATA_W'(-r_g) : DATA_W'(r_g);
    assign w_mabs = r_m[M_W-1] ? M_W'(-r_m) : M_W'(r_m);
    assign w_den  = {1'b0, w_root, 8'd0} + DEN_W'(r_floor);

    // final step: clamp q, apply against the sign of m, saturate to Q8.24
    always_comb begin
        w_qc = (r_q > 64'(Q_LIMIT)) ? Q_LIMIT : r_q[33:0];
        if (r_m[M_W-1]) begin
            w_nw = 35'(r_w) + $signed({1'b0, w_qc});
        end else begin
            w_nw = 35'(r_w) - $signed({1'b0, w_qc});
        end
        if (w_nw > 35'sd2147483647) begin
            w_nw_sat = 32'sh7fff_ffff;
        end else if (w_nw < -35'sd2147483648) begin
            w_nw_sat = 32'sh8000_0000;
        end else begin
            w_nw_sat = w_nw[DATA_W-1:0];
        end
    end

    // unit requests
    always_comb begin
        w_mul_req       = '0;
        w_div_req       = '0;
        w_sqrt_req      = '0;
        w_mul_req.start = !r_go && (r_state == S_POW1 || r_state == S_POW2 ||
                          r_state == S_M1 || r_state == S_M2 ||
                          r_state == S_GSQ || r_state == S_V1 ||
                          r_state == S_V2 || r_state == S_QMUL);
        w_mul_req.clr   = (r_state != S_M2) && (r_state != S_V2);
        case (r_state)
            S_POW1: begin
                w_mul_req.a = MUL_A_W'(r_p1);
                w_mul_req.b = MUL_B_W'(r_beta1);
            end
            S_POW2: begin
                w_mul_req.a = MUL_A_W'(r_p2);
                w_mul_req.b = MUL_B_W'(r_beta2);
            end
            S_M1: begin
                w_mul_req.a = MUL_A_W'($signed(r_m_rd));
                w_mul_req.b = MUL_B_W'(r_beta1);
            end
            S_M2: begin
                w_mul_req.a = MUL_A_W'(r_g);
                w_mul_req.b = MUL_B_W'(ONE_Q32 - POW_W'(r_beta1));
            end
            S_GSQ: begin
                // |g| * |g|: the square is never negative
                w_mul_req.a = MUL_A_W'(w_gabs);
                w_mul_req.b = MUL_B_W'(w_gabs);
            end
            S_V1: begin
                w_mul_req.a = MUL_A_W'(r_v_rd);
                w_mul_req.b = MUL_B_W'(r_beta2);
            end
            S_V2: begin
                w_mul_req.a = MUL_A_W'(r_gsq);
                w_mul_req.b = MUL_B_W'(ONE_Q32 - POW_W'(r_beta2));
            end
            S_QMUL: begin
                w_mul_req.a = MUL_A_W'(r_step);
                w_mul_req.b = r_mhat;
            end
            S_DIV1: begin
                w_div_req.start = !r_go;
                w_div_req.hi    = '0;
                w_div_req.lo    = {w_mabs, 32'd0};
                w_div_req.d     = DIV_W'(w_c1);
            end
            S_DIV2: begin
                w_div_req.start = !r_go;
                w_div_req.hi    = DIV_W'(r_v[V_W-1:24]);
                w_div_req.lo    = {r_v[23:0], 40'd0};
                w_div_req.d     = DIV_W'(w_c2);
            end
            S_QDIV: begin
                w_div_req.start = !r_go;
                w_div_req.hi    = r_prod[2*DIV_W-1:DIV_W];
                w_div_req.lo    = r_prod[DIV_W-1:0];
                w_div_req.d     = DIV_W'(r_den);
            end
            S_SQRT: begin
                w_sqrt_req.start = !r_go;
                w_sqrt_req.x     = r_vhat;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_cnt == (ADDR_W+1)'(WEIGHT_COUNT - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_element_index == '0) ? S_POW1 : S_M1;
                end
            end
            S_POW1: if (r_go && w_mul_done) n_state = S_POW2;
            S_POW2: if (r_go && w_mul_done) n_state = S_M1;
            S_M1:   if (r_go && w_mul_done) n_state = S_M2;
            S_M2:   if (r_go && w_mul_done) n_state = S_GSQ;
            S_GSQ:  if (r_go && w_mul_done) n_state = S_V1;
            S_V1:   if (r_go && w_mul_done) n_state = S_V2;
            S_V2:   if (r_go && w_mul_done) n_state = S_WB;
            S_WB:   n_state = (w_c1 == '0 || w_c2 == '0) ? S_DONE : S_DIV1;
            S_DIV1: if (r_go && w_div_done) n_state = S_DIV2;
            S_DIV2: if (r_go && w_div_done) n_state = S_SQRT;
            S_SQRT: begin
                if (r_go && w_sqrt_done) begin
                    n_state = (w_den == '0) ? S_DONE : S_QMUL;
                end
            end
            S_QMUL: if (r_go && w_mul_done) n_state = S_QDIV;
            S_QDIV: if (r_go && w_div_done) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_go        <= 1'b0;
            r_clr_cnt   <= '0;
            r_p1        <= ONE_Q32;
            r_p2        <= ONE_Q32;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_mul_req.start || w_div_req.start || w_sqrt_req.start) begin
                r_go <= 1'b1;
            end else if (n_state != r_state) begin
                r_go <= 1'b0;
            end
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (r_state == S_POW1 && r_go && w_mul_done) r_p1 <= w_acc[64:32];
            if (r_state == S_POW2 && r_go && w_mul_done) r_p2 <= w_acc[64:32];
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta1 <= RST_BETA_FIRST;
            r_beta2 <= RST_BETA_SECOND;
            r_step  <= RST_STEP_SIZE;
            r_floor <= RST_DEN_FLOOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BETA_FIRST:  r_beta1 <= i_cfg_data;
                CFG_BETA_SECOND: r_beta2 <= i_cfg_data;
                CFG_STEP_SIZE:   r_step  <= i_cfg_data;
                CFG_DEN_FLOOR:   r_floor <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_idx  <= i_element_index;
            r_addr <= ADDR_W'(i_element_index);
            r_w    <= i_weight_value;
            r_g    <= i_gradient_value;
        end
        if (r_go && w_mul_done) begin
            case (r_state)
                S_M2:   r_m <= w_acc[63:32];
                S_GSQ:  r_gsq <= (w_acc[63:56] != '0) ? MAX48 : w_acc[55:8];
                S_V2:   r_v <= w_acc[79:32];
                S_QMUL: r_prod <= w_acc[2*DIV_W-1:0];
                default: begin
                end
            endcase
        end
        if (r_go && w_div_done) begin
            case (r_state)
                S_DIV1: r_mhat <= w_quot;
                S_DIV2: r_vhat <= w_quot;
                S_QDIV: r_q    <= w_quot;
                default: begin
                end
            endcase
        end
        if (r_state == S_SQRT && r_go && w_sqrt_done) begin
            r_den <= w_den;
            if (w_den == '0) r_q <= '0;
        end
        if (r_state == S_WB && (w_c1 == '0 || w_c2 == '0)) begin
            r_q <= '0;   // bias correction undefined: weight passes through
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_idx <= r_idx;
            r_out_w   <= w_nw_sat;
        end
    end

    // moment memories: one read at beat accept, one write-back per beat
    assign w_wr = (r_state == S_WB);

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem_m[r_clr_cnt[ADDR_W-1:0]] <= '0;
        end else if (w_wr) begin
            r_mem_m[r_addr] <= r_m;
        end
        if (w_in_acc) begin
            r_m_rd <= r_mem_m[ADDR_W'(i_element_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem_v[r_clr_cnt[ADDR_W-1:0]] <= '0;
        end else if (w_wr) begin
            r_mem_v[r_addr] <= r_v;
        end
        if (w_in_acc) begin
            r_v_rd <= r_mem_v[ADDR_W'(i_element_index)];
        end
    end

    adw_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_acc   (w_acc),
        .o_done  (w_mul_done)
    );

    adw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    adw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sqrt_req),
        .o_root  (w_root),
        .o_done  (w_sqrt_done)
    );

    assign o_out_valid      = r_out_valid;
    assign o_result_index   = r_out_idx;
    assign o_updated_weight = r_out_w;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the Adam weight update block: random beats, bit-exact prediction.
`timescale 1ns / 1ps
module tb_top;
    import adw_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] g;
    } t_item;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] w;
    } t_update;

    localparam int HOLD_CYCLES = 2500;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_BETA_FIRST;
    logic [DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [IDX_W-1:0] elem_idx = '0;
    logic signed [DATA_W-1:0] weight_in = '0;
    logic signed [DATA_W-1:0] grad_in = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [IDX_W-1:0] res_idx;
    logic signed [DATA_W-1:0] res_weight;

    adam_weight_update u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_element_index  (elem_idx),
        .i_weight_value   (weight_in),
        .i_gradient_value (grad_in),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_result_index   (res_idx),
        .o_updated_weight (res_weight)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // -------------------------------------------------------------------
    // Shadow state of the optimizer, kept in step with accepted beats.
    // Config is only written while idle, so reading it at accept is safe.
    // -------------------------------------------------------------------
    logic [31:0] sh_beta1 = RST_BETA_FIRST;
    logic [31:0] sh_beta2 = RST_BETA_SECOND;
    logic [31:0] sh_step  = RST_STEP_SIZE;
    logic [31:0] sh_floor = RST_DEN_FLOOR;
    logic signed [M_W-1:0] mom1_mem [WEIGHT_COUNT];
    logic [V_W-1:0] mom2_mem [WEIGHT_COUNT];
    logic [POW_W-1:0] pow1 = 33'h1_0000_0000;
    logic [POW_W-1:0] pow2 = 33'h1_0000_0000;

    t_item   pending_q[$];
    t_update weight_q[$];
    int      errors = 0;
    int      beats_in = 0;
    int      beats_out = 0;
    int      phases = 0;
    logic    in_beat = 1'b0;
    logic    calm = 1'b0;
    logic    hold_arm = 1'b0;
    logic    hold_done = 1'b0;
    int      hold_count = 0;

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Saturating 128/64 quotient, clipped to 64 bits.
    function automatic logic [63:0] sat_div(input logic [127:0] num, input logic [63:0] d);
        logic [127:0] quo;
        quo = num / {64'd0, d};
        return (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
    endfunction

    // One Adam update: moments written back, new weight returned.
    function automatic logic [31:0] adam_update(input t_item it);
        logic [ADDR_W-1:0] addr;
        logic [32:0] one_m_b1;
        logic [32:0] one_m_b2;
        logic signed [95:0] macc;
        logic signed [63:0] m64;
        logic signed [63:0] gg;
        logic [63:0] gsq;
        logic [127:0] vacc;
        logic [47:0] v;
        logic [63:0] c1, c2, mag, mhat, vhat, den, q;
        logic signed [65:0] nw;
        addr = it.idx[ADDR_W-1:0];
        if (it.idx == 0) begin
            pow1 = 33'(({31'd0, pow1} * {32'd0, sh_beta1}) >> 32);
            pow2 = 33'(({31'd0, pow2} * {32'd0, sh_beta2}) >> 32);
        end
        one_m_b1 = 33'h1_0000_0000 - {1'b0, sh_beta1};
        one_m_b2 = 33'h1_0000_0000 - {1'b0, sh_beta2};
        macc = $signed({1'b0, sh_beta1}) * mom1_mem[addr]
             + $signed({1'b0, one_m_b1}) * it.g;
        m64 = 64'(macc >>> 32);
        mom1_mem[addr] = m64[31:0];
        gg = it.g * it.g;
        gsq = {8'd0, gg[63:8]};
        if (gsq > 64'hFFFF_FFFF_FFFF) gsq = 64'hFFFF_FFFF_FFFF;
        vacc = {96'd0, sh_beta2} * {80'd0, mom2_mem[addr]}
             + {95'd0, one_m_b2} * {64'd0, gsq};
        v = vacc[79:32];
        mom2_mem[addr] = v;
        c1 = 64'h1_0000_0000 - {31'd0, pow1};
        c2 = 64'h1_0000_0000 - {31'd0, pow2};
        q = '0;
        if (c1 != 0 && c2 != 0) begin
            mag = (m64 < 0) ? 64'(-m64) : 64'(m64);
            mhat = sat_div({32'd0, mag, 32'd0}, c1);
            vhat = sat_div({40'd0, v, 40'd0}, c2);
            den = (isqrt(vhat) << 8) + {32'd0, sh_floor};
            if (den != 0) q = sat_div({96'd0, sh_step} * {64'd0, mhat}, den);
        end
        if (q > 64'h2_0000_0000) q = 64'h2_0000_0000;
        nw = (m64 < 0) ? it.w + $signed({2'b0, q}) : it.w - $signed({2'b0, q});
        if (nw > 66'sd2147483647) nw = 66'sd2147483647;
        if (nw < -66'sd2147483648) nw = -66'sd2147483648;
        return nw[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %h want %h (result beat %0d)", what, got, want, beats_out);
    endtask

    // -------------------------------------------------------------------
    // Monitor: predicts on input beats, checks output beats.
    // -------------------------------------------------------------------
    always @(posedge clk) begin
        t_item it;
        t_update exp_u;
        in_beat <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            it.idx = elem_idx;
            it.w = weight_in;
            it.g = grad_in;
            exp_u.idx = it.idx;
            exp_u.w = adam_update(it);
            weight_q.push_back(exp_u);
            beats_in++;
        end
        if (rst_n && out_valid && !out_stall) begin
            beats_out++;
            if (weight_q.size() == 0) begin
                report_mismatch("unexpected beat", {22'd0, res_idx}, 32'd0);
            end else begin
                exp_u = weight_q.pop_front();
                if (res_idx !== exp_u.idx)
                    report_mismatch("result_index", {22'd0, res_idx}, {22'd0, exp_u.idx});
                if (res_weight !== exp_u.w)
                    report_mismatch("updated_weight", res_weight, exp_u.w);
            end
        end
    end

    // Driver: holds a payload until accepted, random gaps unless calm.
    always @(negedge clk) begin
        t_item it;
        if (!in_valid || in_beat) begin
            if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
                it = pending_q.pop_front();
                in_valid <= 1'b1;
                elem_idx <= it.idx;
                weight_in <= it.w;
                grad_in <= it.g;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once armed.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b1;
        end else if (hold_arm && !hold_done) begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(99) < 22);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_BETA_FIRST:  sh_beta1 = data;
            CFG_BETA_SECOND: sh_beta2 = data;
            CFG_STEP_SIZE:   sh_step = data;
            default:         sh_floor = data;
        endcase
    endtask

    task automatic set_config(input logic [31:0] b1, input logic [31:0] b2,
                              input logic [31:0] lr, input logic [31:0] eps);
        write_reg(CFG_BETA_FIRST, b1);
        write_reg(CFG_BETA_SECOND, b2);
        write_reg(CFG_STEP_SIZE, lr);
        write_reg(CFG_DEN_FLOOR, eps);
        phases++;
    endtask

    task automatic add_item(input logic [9:0] idx, input logic [31:0] w, input logic [31:0] g);
        t_item it;
        it.idx = idx;
        it.w = w;
        it.g = g;
        pending_q.push_back(it);
    endtask

    // Values spread over magnitudes; full-range values keep every bit moving.
    function automatic logic [31:0] rand_fix();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: return r;
            1: return 32'($signed(r) >>> $urandom_range(8, 28));
            2: return 32'($signed(r) >>> $urandom_range(1, 7));
            default: return ($urandom_range(9) == 0) ? 32'd0 : r;
        endcase
    endfunction

    // Mostly well-formed steps (index 0 up to n-1), some stray indexes.
    task automatic add_random(input int count);
        int n, left;
        left = count;
        while (left > 0) begin
            if ($urandom_range(99) < 15) begin
                add_item(10'($urandom), rand_fix(), rand_fix());
                left--;
            end else begin
                n = ($urandom_range(19) == 0) ? $urandom_range(100, 1024) : $urandom_range(1, 40);
                for (int i = 0; i < n && left > 0; i++) begin
                    add_item(10'(i), rand_fix(), rand_fix());
                    left--;
                end
            end
        end
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || in_valid || weight_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial begin
        for (int i = 0; i < WEIGHT_COUNT; i++) begin
            mom1_mem[i] = '0;
            mom2_mem[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: no step started yet, so weights pass through.
        add_item(10'd5, 32'h7FFF_FFFF, 32'h8000_0000);
        add_item(10'd1023, 32'h8000_0000, 32'h7FFF_FFFF);
        add_item(10'd6, 32'h0100_0000, 32'h0000_0001);
        // First step, extremes of weight and gradient.
        add_item(10'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_item(10'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        add_item(10'd1023, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_item(10'd512, 32'h0000_0000, 32'h0000_0000);
        add_item(10'd2, 32'hFFFF_FFFF, 32'h0000_0001);
        add_item(10'd3, 32'h8000_0000, 32'h8000_0000);
        add_item(10'd4, 32'h0000_0001, 32'h0100_0000);
        for (int s = 0; s < 3; s++) begin
            add_item(10'd0, 32'h0080_0000, 32'hFF00_0000);
            add_item(10'd1, 32'h8000_0001, 32'h0000_0100);
            add_item(10'd1023, 32'h7FFF_FFFE, 32'hFFFF_FF00);
        end
        drain();

        // Zero divisor: no epsilon and a fresh element with zero gradient.
        set_config(RST_BETA_FIRST, RST_BETA_SECOND, RST_STEP_SIZE, 32'd0);
        add_item(10'd700, 32'h1234_5678, 32'h0000_0000);
        add_item(10'd701, 32'hEDCB_A987, 32'h0000_0010);
        drain();

        // Defaults again, with a long receiver hold-off to back the block up.
        set_config(RST_BETA_FIRST, RST_BETA_SECOND, RST_STEP_SIZE, RST_DEN_FLOOR);
        hold_arm = 1'b1;
        add_random(250);
        drain();

        // Low extremes with no idling on either side.
        calm = 1'b1;
        set_config(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        add_random(250);
        drain();
        calm = 1'b0;

        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_random(250);
        drain();

        set_config(32'h8000_0000, 32'hF000_0000, 32'd0, 32'd1);
        add_random(200);
        drain();

        for (int k = 0; k < 3; k++) begin
            set_config($urandom, $urandom, $urandom >> $urandom_range(0, 24),
                       $urandom >> $urandom_range(0, 31));
            add_random(250);
            drain();
        end

        repeat (200) @(posedge clk);
        $display("tb: %0d input beats and %0d result beats over %0d register settings",
                 beats_in, beats_out, phases);
        $display("tb: %0d mismatches, %0d updates still expected", errors, weight_q.size());
        if (errors == 0 && weight_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("tb: timeout with %0d updates expected", weight_q.size());
        $display("tb: failure");
        $finish;
    end

endmodule
